// File: hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the bump filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property at each rising edge of clk while rst_n is high.
`define ASSERT_AT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checks that a condition never holds at a rising edge of clk outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// File: hw/rtl/bef_pkg.sv
// Types, constants and helper functions of the bump filter.
package bef_pkg;

    localparam int MAX_LINE_WIDTH = 1024;
    localparam int DELAY_DEPTH    = 3 * MAX_LINE_WIDTH + 2;
    localparam int ADDR_W         = $clog2(DELAY_DEPTH);
    localparam int CNT_W          = $clog2(DELAY_DEPTH + 1);
    localparam int EFF_W          = $clog2(MAX_LINE_WIDTH + 1);
    localparam int PIX_W          = 8;
    localparam int LW_W           = 11;
    localparam int APB_ADDR_W     = 4;
    localparam int APB_DATA_W     = 32;

    localparam logic [LW_W-1:0]  LINE_WIDTH_RST = LW_W'(640);
    localparam logic [PIX_W-1:0] PIX_MID        = PIX_W'(128);
    localparam logic [PIX_W-1:0] PIX_WHITE      = PIX_W'(255);

    typedef enum logic [1:0] {
        REG_LINE_WIDTH = 2'd0,
        REG_WHITE      = 2'd1,
        REG_DOUBLE     = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [CNT_W-1:0] delta;
        logic             white;
        logic             double_w;
    } t_cfg;

    // Diagonal offset 3*w+2 with the line width clamped to 1..MAX_LINE_WIDTH.
    function automatic logic [CNT_W-1:0] f_delta(input logic [LW_W-1:0] w);
        logic [EFF_W-1:0] eff;
        if (w == '0) begin
            eff = EFF_W'(1);
        end else if (32'(w) > MAX_LINE_WIDTH) begin
            eff = EFF_W'(MAX_LINE_WIDTH);
        end else begin
            eff = EFF_W'(w);
        end
        return CNT_W'({eff, 1'b0}) + CNT_W'(eff) + CNT_W'(2);
    endfunction

endpackage

// File: hw/rtl/bump_emboss_pixel_filter.sv
// Top level of the bump (emboss) pixel filter.
//
//  Channel    Direction  Payload
//  s_axis     in         tdata = pixel_in[7:0], tuser = frame_start
//  m_axis     out        tdata = pixel_out[7:0], tlast = last_copy
//  apb        in/out     line_width @0x0, white_pass @0x4, double_width @0x8
//
// An input beat is taken every cycle in normal mode while m_axis is ready; in
// double-width mode the output register sends each result twice and takes the
// next pixel only once the second copy leaves. The first output beat passes the
// stage register, which the delay line read joins, and then the output register.
// Reset clears the write pointer, the position counter and the pipeline valid
// flags; the delay line itself is not cleared and needs no sweep.
// A stall on m_axis holds the output register; the one stage in front of it
// still takes an input beat, and only then s_axis_tready falls.
`include "assert_macros.svh"

module bump_emboss_pixel_filter
    import bef_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [PIX_W-1:0]      s_axis_tdata,   // [7:0] pixel_in
    input  logic                  s_axis_tuser,   // [0] frame_start
    // Output stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [PIX_W-1:0]      m_axis_tdata,   // [7:0] pixel_out
    output logic                  m_axis_tlast,
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg             cfg;

    logic [ADDR_W-1:0] r_wp;
    logic [ADDR_W-1:0] n_wp;
    logic [CNT_W-1:0]  r_pc;
    logic [CNT_W-1:0]  n_pc;
    logic              r_s1_valid;
    logic [PIX_W-1:0]  r_s1_pix;
    logic              r_s1_border;

    logic              accept;
    logic              take;
    logic [CNT_W-1:0]  pc_eff;
    logic              border;
    logic [CNT_W-1:0]  wp_ext;
    logic [CNT_W-1:0]  rd_ext;
    logic [ADDR_W-1:0] raddr;
    logic [PIX_W-1:0]  old_pix;
    logic [PIX_W:0]    diff;
    logic [PIX_W-1:0]  res;

    bef_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // The stage register in front of the output takes a new beat whenever it
    // is empty or hands its pixel on in the same cycle.
    assign s_axis_tready = !r_s1_valid || take;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // A frame start restarts the count before this pixel is judged.
    assign pc_eff = s_axis_tuser ? '0 : r_pc;
    assign border = pc_eff < cfg.delta;
    assign n_pc   = border ? pc_eff + CNT_W'(1) : pc_eff;
    assign n_wp   = (r_wp == ADDR_W'(DELAY_DEPTH - 1)) ? '0 : r_wp + ADDR_W'(1);

    // Partner pixel sits delta entries behind the write pointer in the ring.
    // At the widest setting the offset equals the ring depth, so the read hits
    // the entry being written in the same cycle; the RAM then returns the older
    // content, which is exactly the partner pixel.
    assign wp_ext = CNT_W'(r_wp);
    assign rd_ext = (wp_ext >= cfg.delta) ? wp_ext - cfg.delta
                                          : wp_ext - cfg.delta + CNT_W'(DELAY_DEPTH);
    assign raddr  = rd_ext[ADDR_W-1:0];

    bef_delay_ram #(
        .DEPTH (DELAY_DEPTH),
        .WIDTH (PIX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_wp),
        .i_wdata (s_axis_tdata),
        .i_re    (accept),
        .i_raddr (raddr),
        .o_rdata (old_pix)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp       <= '0;
            r_pc       <= '0;
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_wp       <= n_wp;
            r_pc       <= n_pc;
            r_s1_valid <= 1'b1;
        end else if (take) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix    <= s_axis_tdata;
            r_s1_border <= border;
        end
    end

    // (256 + current - partner) / 2, with the leading border and white pass.
    assign diff = {1'b1, r_s1_pix} - {1'b0, old_pix};

    always_comb begin
        priority if (r_s1_border) begin
            res = PIX_MID;
        end else if (cfg.white && r_s1_pix == PIX_WHITE) begin
            res = PIX_WHITE;
        end else begin
            res = diff[PIX_W:1];
        end
    end

    bef_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (r_s1_valid),
        .i_pix         (res),
        .i_double      (cfg.double_w),
        .o_take        (take),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    `ASSERT_NEVER(a_rd_range, i_clk, i_rst_n, raddr > ADDR_W'(DELAY_DEPTH - 1))
    `ASSERT_NEVER(a_pc_range, i_clk, i_rst_n, r_pc > CNT_W'(DELAY_DEPTH))
    `ASSERT_AT(a_first_copy_double, i_clk, i_rst_n,
               (m_axis_tvalid && !m_axis_tlast) |-> cfg.double_w)
    `ASSERT_AT(a_s1_hold, i_clk, i_rst_n,
               (r_s1_valid && !take) |=> (r_s1_valid && $stable(r_s1_pix)))

endmodule

// File: hw/rtl/bef_delay_ram.sv
// Simple dual-port synchronous RAM with registered read data.
module bef_delay_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/bef_regs.sv
// APB register file of the bump filter with the precomputed diagonal offset.
module bef_regs
    import bef_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    logic [LW_W-1:0]  r_line_width;
    logic [CNT_W-1:0] r_delta;
    logic             r_white;
    logic             r_double;
    logic             wr_en;
    t_reg_idx         idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LINE_WIDTH_RST;
            r_delta      <= f_delta(LINE_WIDTH_RST);
            r_white      <= 1'b0;
            r_double     <= 1'b0;
        end else if (wr_en) begin
            unique case (idx)
                REG_LINE_WIDTH: begin
                    r_line_width <= pwdata[LW_W-1:0];
                    r_delta      <= f_delta(pwdata[LW_W-1:0]);
                end
                REG_WHITE:  r_white  <= pwdata[0];
                REG_DOUBLE: r_double <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (idx)
            REG_LINE_WIDTH: prdata = APB_DATA_W'(r_line_width);
            REG_WHITE:      prdata = APB_DATA_W'(r_white);
            REG_DOUBLE:     prdata = APB_DATA_W'(r_double);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.delta    = r_delta;
    assign o_cfg.white    = r_white;
    assign o_cfg.double_w = r_double;

endmodule

// File: hw/rtl/bef_emit.sv
// Output register of the bump filter that sends each result once or twice.
module bef_emit
    import bef_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [PIX_W-1:0] i_pix,
    input  logic             i_double,
    output logic             o_take,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [PIX_W-1:0] m_axis_tdata,
    output logic             m_axis_tlast
);

    logic             r_valid;
    logic             r_last;
    logic [PIX_W-1:0] r_pix;
    logic             can_load;

    // A new result may enter once the final copy of the held one leaves.
    assign can_load = !r_valid || (m_axis_tready && r_last);
    assign o_take   = i_valid && can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else if (o_take) begin
            r_valid <= 1'b1;
            r_last  <= !i_double;
        end else if (r_valid && m_axis_tready) begin
            if (r_last) begin
                r_valid <= 1'b0;
            end else begin
                r_last <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_pix <= i_pix;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_pix;
    assign m_axis_tlast  = r_last;

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the bump (emboss) pixel filter.
//
// A queue of pixel beats, filled by the stimulus process, feeds a clocked driver on s_axis.
// Each accepted beat goes through an emboss predictor at the moment it is taken. The predictor
// keeps its own delay line, frame position and register copies. A clocked monitor on m_axis
// compares every output beat, pixel and last flag, with the oldest predicted result.
// Registers are written over the APB port only while the filter is drained.
// The run starts with a short directed sequence. It covers the leading border, white
// pass-through, double width, a stream that starts without a frame start, a zero line width,
// and a width raised in the middle of a frame. Random phases follow, most of them with small
// line widths and well-formed frames. One long frame at a wide setting runs far past its
// border; a width above the maximum then continues it and drops back into the border.
module testbench;
    import bef_pkg::*;

    localparam int CYCLE_LIMIT  = 400_000;
    localparam int DRAIN_CYCLES = 10;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
        bit               hold;      // wait for the filter to drain before offering it
    } t_pixel_beat;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } t_emboss_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [PIX_W-1:0]      s_axis_tdata  = '0;    // [7:0] pixel_in
    logic                  s_axis_tuser  = 1'b0;  // [0] frame_start
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [PIX_W-1:0]      m_axis_tdata;          // [7:0] pixel_out
    logic                  m_axis_tlast;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Register copies used by the predictor. They change only while the filter is idle.
    logic [LW_W-1:0] cfg_line_width = LINE_WIDTH_RST;
    logic            cfg_white      = 1'b0;
    logic            cfg_double     = 1'b0;

    // Predictor state: its own delay line, write pointer and frame position.
    logic [PIX_W-1:0] history [DELAY_DEPTH] = '{default: '0};
    int unsigned      hist_wr   = 0;
    int unsigned      frame_pos = 0;

    t_pixel_beat    pixel_queue[$];
    t_emboss_result embossed_queue[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned cycle_count   = 0;
    int unsigned error_count   = 0;
    int unsigned beats_in      = 0;
    int unsigned beats_out     = 0;
    int unsigned frames_seen   = 0;
    int unsigned settings_used = 0;

    always #5 i_clk = ~i_clk;

    bump_emboss_pixel_filter i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    task automatic report_mismatch(input string msg);
        $display("ERROR cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Distance back to the partner pixel, three lines up and two pixels left.
    // A zero width behaves as one, and widths above the maximum are clamped.
    function automatic int unsigned diag_offset(input logic [LW_W-1:0] w);
        int unsigned eff;
        if (w == '0) begin
            eff = 1;
        end else if (int'(w) > MAX_LINE_WIDTH) begin
            eff = MAX_LINE_WIDTH;
        end else begin
            eff = int'(w);
        end
        return 3 * eff + 2;
    endfunction

    // Works out the output beats of one accepted pixel and queues them.
    function automatic void emboss_predict(input logic [PIX_W-1:0] pix, input logic fs);
        int unsigned      delta;
        logic [PIX_W-1:0] earlier;
        logic [PIX_W-1:0] value;
        t_emboss_result   res;
        delta = diag_offset(cfg_line_width);
        if (fs) begin
            frame_pos = 0;
        end
        earlier = history[(hist_wr + DELAY_DEPTH - delta) % DELAY_DEPTH];
        // The border rule wins over white pass-through.
        if (frame_pos < delta) begin
            value = PIX_MID;
        end else if (cfg_white && pix == PIX_WHITE) begin
            value = PIX_WHITE;
        end else begin
            value = PIX_W'((256 + int'(pix) - int'(earlier)) >> 1);
        end
        history[hist_wr] = pix;
        hist_wr = (hist_wr + 1) % DELAY_DEPTH;
        if (frame_pos < delta) begin
            frame_pos++;
        end
        res.pixel = value;
        if (cfg_double) begin
            res.last = 1'b0;
            embossed_queue.push_back(res);
        end
        res.last = 1'b1;
        embossed_queue.push_back(res);
    endfunction

    // Input driver. A new beat is offered only when the previous one has been taken, so
    // tvalid never drops while a beat is pending.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                emboss_predict(s_axis_tdata, s_axis_tuser);
                void'(pixel_queue.pop_front());
                beats_in++;
                if (s_axis_tuser) begin
                    frames_seen++;
                end
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pixel_queue.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if (pixel_queue[0].hold && embossed_queue.size() != 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if ($urandom_range(99) < send_idle_pct) begin
                    s_axis_tvalid <= 1'b0;
                end else begin
                    s_axis_tvalid     <= 1'b1;
                    s_axis_tdata      <= pixel_queue[0].pixel;
                    s_axis_tuser      <= pixel_queue[0].frame_start;
                    pixel_queue[0].hold = 1'b0;
                end
            end
        end
    end

    // Output monitor. Every output beat must match the oldest predicted result.
    always @(posedge i_clk) begin : result_monitor
        t_emboss_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                beats_out++;
                if (embossed_queue.size() == 0) begin
                    report_mismatch($sformatf("output beat with nothing expected: pixel %0d last %0b",
                                              m_axis_tdata, m_axis_tlast));
                end else begin
                    want = embossed_queue.pop_front();
                    if (m_axis_tdata !== want.pixel) begin
                        report_mismatch($sformatf("pixel_out %0d, expected %0d",
                                                  m_axis_tdata, want.pixel));
                    end
                    if (m_axis_tlast !== want.last) begin
                        report_mismatch($sformatf("last_copy %0b, expected %0b (pixel %0d)",
                                                  m_axis_tlast, want.last, want.pixel));
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Run timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, embossed_queue.size());
            $display("bump_emboss_pixel_filter: mismatch");
            $finish;
        end
    end

    // One APB write: a setup phase, then an access phase that completes while pready is high.
    task automatic apb_write(input t_reg_idx idx, input int unsigned value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_LINE_WIDTH: cfg_line_width = value[LW_W-1:0];
            REG_WHITE:      cfg_white      = value[0];
            REG_DOUBLE:     cfg_double     = value[0];
            default: ;
        endcase
    endtask

    task automatic set_mode(input int unsigned width, input bit white, input bit dbl,
                            input int unsigned send_pct, input int unsigned recv_pct);
        apb_write(REG_LINE_WIDTH, width);
        apb_write(REG_WHITE, 32'(white));
        apb_write(REG_DOUBLE, 32'(dbl));
        @(negedge i_clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        settings_used++;
    endtask

    task automatic queue_pixel(input logic [PIX_W-1:0] pix, input logic fs, input bit hold);
        t_pixel_beat beat;
        beat.pixel       = pix;
        beat.frame_start = fs;
        beat.hold        = hold;
        pixel_queue.push_back(beat);
    endtask

    // Random frames for the current width. Most frames run well past the border. With
    // stray_pct above zero, some frames are cut short and a few starts land mid-frame.
    // One beat in the middle waits until the filter has drained.
    task automatic queue_random_frames(input int count, input bit first_start,
                                       input int unsigned stray_pct);
        int unsigned delta;
        int unsigned left;
        int unsigned pause_at;
        int unsigned pick;
        logic        fs;
        logic [PIX_W-1:0] pix;
        delta    = diag_offset(cfg_line_width);
        left     = first_start ? 0 : $urandom_range(3 * delta, delta);
        pause_at = $urandom_range(3 * count / 4, count / 4);
        for (int i = 0; i < count; i++) begin
            fs = 1'b0;
            if (left == 0) begin
                fs = 1'b1;
                if (stray_pct != 0 && $urandom_range(9) == 0) begin
                    left = $urandom_range(delta, 1);
                end else begin
                    left = $urandom_range(3 * delta, delta);
                end
            end else if ($urandom_range(99) < stray_pct) begin
                fs = 1'b1;
            end
            left--;
            pick = $urandom_range(15);
            if (pick < 2) begin
                pix = PIX_WHITE;
            end else if (pick == 2) begin
                pix = '0;
            end else begin
                pix = PIX_W'($urandom());
            end
            queue_pixel(pix, fs, i == pause_at);
        end
    endtask

    // Waits until every queued beat has been taken and every result has come out.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pixel_queue.size() != 0 || embossed_queue.size() != 0 || s_axis_tvalid);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [PIX_W-1:0] opening [11] = '{255, 0, 255, 128, 1, 255, 0, 0, 255, 254, 7};
        logic [PIX_W-1:0] raised  [11] = '{255, 0, 255, 0, 255, 0, 255, 0, 255, 0, 128};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Width 0 behaves as width 1, so the border is five pixels long.
        // White pass-through and double width are both on. The first beats carry no frame
        // start, so the stream counts as a frame from its first pixel. A 255 inside the
        // border must still give 128. Past the border, 255 passes through and the
        // differences reach 0 at the low end and 254 near the top of the range.
        set_mode(0, 1'b1, 1'b1, 26, 65);
        foreach (opening[i]) begin
            queue_pixel(opening[i], 1'b0, 1'b0);
        end
        // A frame start sends the output back to the flat border.
        queue_pixel(8'd255, 1'b1, 1'b0);
        queue_pixel(8'd200, 1'b0, 1'b0);
        queue_pixel(8'd3, 1'b0, 1'b0);
        wait_drained();

        // The width is raised in the middle of a frame. The border then lasts until the
        // new, longer offset has been reached. Alternating extremes push a difference down to
        // 0 while white pass-through is off.
        set_mode(2, 1'b0, 1'b0, 26, 65);
        foreach (raised[i]) begin
            queue_pixel(raised[i], 1'b0, 1'b0);
        end
        wait_drained();

        // Random phases. The sender idles less than the receiver.
        set_mode(1, 1'b0, 1'b0, 26, 65);
        queue_random_frames(150, 1'b1, 2);
        wait_drained();
        set_mode(2, 1'b1, 1'b1, 26, 65);
        queue_random_frames(150, 1'b0, 2);
        wait_drained();
        set_mode(3, 1'($urandom_range(1)), 1'($urandom_range(1)), 26, 65);
        queue_random_frames(200, 1'b1, 3);
        wait_drained();

        // Now the receiver idles less than the sender.
        set_mode(7, 1'b1, 1'b0, 65, 26);
        queue_random_frames(150, 1'b1, 2);
        wait_drained();
        set_mode(20, 1'b0, 1'b1, 65, 26);
        queue_random_frames(150, 1'b1, 2);
        wait_drained();

        // Neither side idles. One long frame at a wide line width runs far past its
        // 602-pixel border. Then an out-of-range width, clamped to the widest offset,
        // continues that frame without a frame start and falls back into the border.
        set_mode(200, 1'b1, 1'b0, 0, 0);
        for (int i = 0; i < 900; i++) begin
            queue_pixel(PIX_W'($urandom()), i == 0, 1'b0);
        end
        wait_drained();
        set_mode(2047, 1'b0, 1'b1, 0, 0);
        queue_random_frames(60, 1'b0, 0);
        wait_drained();
        set_mode(0, 1'b1, 1'b0, 0, 0);
        queue_random_frames(150, 1'b1, 2);
        wait_drained();

        $display("Sent %0d pixels in %0d frames under %0d register settings.",
                 beats_in, frames_seen, settings_used);
        $display("Checked %0d output beats, with line widths 0 to 2047 and all mode flags.",
                 beats_out);
        if (error_count == 0) begin
            $display("bump_emboss_pixel_filter: match");
        end else begin
            $display("bump_emboss_pixel_filter: mismatch");
        end
        $finish;
    end

endmodule
